>>> rtl/core/qcncp_pkg.sv
// Shared types, constants and arithmetic helpers of the QCN congestion point.
package qcncp_pkg;

   // Field widths.
   localparam int QUEUE_W    = 24;
   localparam int LEN_W      = 14;
   localparam int RND_W      = 8;
   localparam int WEIGHT_W   = 4;
   localparam int DIFF_W     = 25;
   localparam int RAW_W      = 30;
   localparam int NEG_W      = 28;
   localparam int KBN_W      = 29;
   localparam int KBQ_W      = 20;
   localparam int MAG_W      = 19;
   localparam int QUANT_W    = 6;
   localparam int PERIOD_W   = 32;
   localparam int CNT_W      = 33;
   localparam int RELOAD_W   = PERIOD_W + RND_W;
   localparam int RND_SHIFT  = 7;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam int PERIOD_REGS = 4;

   // Division by one kilobyte: multiply by a truncated reciprocal, then correct by one.
   localparam int KBYTE     = 1000;
   localparam int KB_SHIFT  = 39;
   localparam int KB_PROD_W = KBN_W + 30;
   localparam logic [29:0] KB_RECIP = 30'd549755813;

   // Item commands.
   localparam logic CMD_ARRIVAL   = 1'b0;
   localparam logic CMD_DEPARTURE = 1'b1;

   // Register reset values.
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET     = 4'd2;
   localparam logic [QUEUE_W-1:0]  MAX_QUEUE_RESET  = 24'hFFFFFF;
   localparam logic                QCN_ENABLE_RESET = 1'b1;

   // Register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_EQ_POINT     = 3'd0,
      CSR_WEIGHT       = 3'd1,
      CSR_MAX_QUEUE    = 3'd2,
      CSR_QCN_ENABLE   = 3'd3,
      CSR_PERIODS_0_1  = 3'd4,
      CSR_PERIODS_2_3  = 3'd5,
      CSR_PERIODS_4_5  = 3'd6,
      CSR_PERIODS_6_7  = 3'd7
   } csr_index_type;

   // Configuration as seen by the datapath.
   typedef struct packed {
      logic [QUEUE_W-1:0]                       eq_point;
      logic [WEIGHT_W-1:0]                      weight;
      logic [QUEUE_W-1:0]                       max_queue;
      logic                                     qcn_enable;
      logic [PERIOD_REGS-1:0][CSR_DATA_W-1:0]   periods;
      logic [KBQ_W-1:0]                         lo_limit;
   } cfg_type;

   // Item after the queue and sampling state update.
   typedef struct packed {
      logic                accepted;
      logic                sample;
      logic [RND_W-1:0]    rnd;
      logic [QUEUE_W-1:0]  q_now;
      logic [QUEUE_W-1:0]  qold;
   } cp_item_type;

   // Item leaving the feedback pipeline.
   typedef struct packed {
      logic                       accepted;
      logic                       sample;
      logic [RND_W-1:0]           rnd;
      logic [QUANT_W-1:0]         quant;
      logic signed [DIFF_W-1:0]   offset;
      logic signed [DIFF_W-1:0]   delta;
      logic [QUEUE_W-1:0]         q_now;
   } fb_out_type;

   // Status of the sampling state.
   typedef struct packed {
      logic pending;
   } cp_status_type;

   // First estimate of n / 1000; it is the true quotient or one less.
   function automatic logic [KBQ_W-1:0] kb_quot_est(input logic [KBN_W-1:0] n);
      logic [KB_PROD_W-1:0] prod;
      prod = KB_PROD_W'(n) * KB_PROD_W'(KB_RECIP);
      return prod[KB_SHIFT +: KBQ_W];
   endfunction

   // Corrects the estimate by one where the remainder reaches a kilobyte.
   function automatic logic [KBQ_W-1:0] kb_quot_fix(input logic [KBN_W-1:0] n,
                                                    input logic [KBQ_W-1:0] q0);
      logic [KBN_W:0] prod;
      logic [KBN_W:0] rem;
      prod = (KBN_W+1)'(q0) * (KBN_W+1)'(KBYTE);
      rem  = {1'b0, n} - prod;
      return (rem >= (KBN_W+1)'(KBYTE)) ? q0 + KBQ_W'(1) : q0;
   endfunction

   // Values below 64 pass; larger ones keep their top six bits.
   function automatic logic [QUANT_W-1:0] quantize6(input logic [MAG_W-1:0] mag);
      logic [QUANT_W-1:0] q;
      q = mag[QUANT_W-1:0];
      for (int p = QUANT_W; p < MAG_W; p++) begin
         if (mag[p]) begin
            q = mag[p -: QUANT_W];
         end
      end
      return q;
   endfunction

   // Sampling period table: two 32-bit entries packed in each register.
   function automatic logic [PERIOD_W-1:0] period_entry(
      input logic [PERIOD_REGS-1:0][CSR_DATA_W-1:0] periods,
      input logic [2:0]                             idx);
      logic [CSR_DATA_W-1:0] word;
      word = periods[idx[2:1]];
      return idx[0] ? word[CSR_DATA_W-1:PERIOD_W] : word[PERIOD_W-1:0];
   endfunction

endpackage

>>> rtl/core/qcncp_csr.sv
// Configuration registers and the precomputed feedback clamp limit.
module qcncp_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_enable,
   input  logic [qcncp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [qcncp_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output qcncp_pkg::cfg_type                     cfg
);

   logic [qcncp_pkg::QUEUE_W-1:0]  eq_ff, eq_in;
   logic [qcncp_pkg::WEIGHT_W-1:0] weight_ff, weight_in;
   logic [qcncp_pkg::QUEUE_W-1:0]  maxq_ff, maxq_in;
   logic                           enable_ff, enable_in;
   logic [qcncp_pkg::PERIOD_REGS-1:0][qcncp_pkg::CSR_DATA_W-1:0] periods_ff, periods_in;

   logic [qcncp_pkg::KBN_W-1:0] lo_prod_ff, lo_prod_in;
   logic [qcncp_pkg::KBN_W-1:0] lo_n_ff, lo_n_in;
   logic [qcncp_pkg::KBQ_W-1:0] lo_q0_ff, lo_q0_in;
   logic [qcncp_pkg::KBQ_W-1:0] lo_ff, lo_in;

   // Register write decode.
   always_comb begin
      eq_in      = eq_ff;
      weight_in  = weight_ff;
      maxq_in    = maxq_ff;
      enable_in  = enable_ff;
      periods_in = periods_ff;
      if (csr_write_enable) begin
         unique case (qcncp_pkg::csr_index_type'(csr_index))
            qcncp_pkg::CSR_EQ_POINT:    eq_in = csr_wdata[qcncp_pkg::QUEUE_W-1:0];
            qcncp_pkg::CSR_WEIGHT:      weight_in = csr_wdata[qcncp_pkg::WEIGHT_W-1:0];
            qcncp_pkg::CSR_MAX_QUEUE:   maxq_in = csr_wdata[qcncp_pkg::QUEUE_W-1:0];
            qcncp_pkg::CSR_QCN_ENABLE:  enable_in = csr_wdata[0];
            qcncp_pkg::CSR_PERIODS_0_1: periods_in[0] = csr_wdata;
            qcncp_pkg::CSR_PERIODS_2_3: periods_in[1] = csr_wdata;
            qcncp_pkg::CSR_PERIODS_4_5: periods_in[2] = csr_wdata;
            qcncp_pkg::CSR_PERIODS_6_7: periods_in[3] = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eq_ff      <= '0;
         weight_ff  <= qcncp_pkg::WEIGHT_RESET;
         maxq_ff    <= qcncp_pkg::MAX_QUEUE_RESET;
         enable_ff  <= qcncp_pkg::QCN_ENABLE_RESET;
         periods_ff <= '0;
      end else begin
         eq_ff      <= eq_in;
         weight_ff  <= weight_in;
         maxq_ff    <= maxq_in;
         enable_ff  <= enable_in;
         periods_ff <= periods_in;
      end
   end

   // Clamp limit eq*(2w+1)/1000, recomputed every cycle over three stages.
   always_comb begin
      lo_prod_in = qcncp_pkg::KBN_W'(eq_ff) * qcncp_pkg::KBN_W'({weight_ff, 1'b1});
      lo_n_in    = lo_prod_ff;
      lo_q0_in   = qcncp_pkg::kb_quot_est(lo_prod_ff);
      lo_in      = qcncp_pkg::kb_quot_fix(lo_n_ff, lo_q0_ff);
   end

   always_ff @(posedge clock) begin
      lo_prod_ff <= lo_prod_in;
      lo_n_ff    <= lo_n_in;
      lo_q0_ff   <= lo_q0_in;
      lo_ff      <= lo_in;
   end

   always_comb begin
      cfg.eq_point   = eq_ff;
      cfg.weight     = weight_ff;
      cfg.max_queue  = maxq_ff;
      cfg.qcn_enable = enable_ff;
      cfg.periods    = periods_ff;
      cfg.lo_limit   = lo_ff;
   end

endmodule

>>> rtl/core/qcncp_state.sv
// Queue length, last-sample queue length and sampling byte counter.
module qcncp_state (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              go,
   input  logic                              cmd,
   input  logic [qcncp_pkg::LEN_W-1:0]       len,
   input  logic [qcncp_pkg::RND_W-1:0]       rnd,
   input  logic [qcncp_pkg::QUEUE_W-1:0]     max_queue,
   input  logic                              reload_we,
   input  logic [qcncp_pkg::CNT_W-1:0]       reload_value,
   output qcncp_pkg::cp_item_type            item,
   output qcncp_pkg::cp_status_type          status
);

   logic [qcncp_pkg::QUEUE_W-1:0] queue_ff, queue_in;
   logic [qcncp_pkg::QUEUE_W-1:0] qold_ff, qold_in;
   logic [qcncp_pkg::CNT_W-1:0]   count_ff, count_in;
   logic                          pending_ff, pending_in;

   logic                          is_arrival;
   logic [qcncp_pkg::QUEUE_W:0]   sum;
   logic                          accepted;
   logic                          sample;
   logic [qcncp_pkg::QUEUE_W-1:0] q_now;

   // Queue update and sampling decision for the item in the input register.
   always_comb begin
      is_arrival = (cmd == qcncp_pkg::CMD_ARRIVAL);
      sum        = {1'b0, queue_ff} + (qcncp_pkg::QUEUE_W+1)'(len);
      accepted   = is_arrival && (sum <= {1'b0, max_queue});
      sample     = accepted && (qcncp_pkg::CNT_W'(len) > count_ff);
      if (!is_arrival) begin
         q_now = (queue_ff > qcncp_pkg::QUEUE_W'(len)) ?
                 queue_ff - qcncp_pkg::QUEUE_W'(len) : '0;
      end else if (accepted) begin
         q_now = sum[qcncp_pkg::QUEUE_W-1:0];
      end else begin
         q_now = queue_ff;
      end

      item.accepted = accepted;
      item.sample   = sample;
      item.rnd      = rnd;
      item.q_now    = q_now;
      item.qold     = qold_ff;
      status.pending = pending_ff;
   end

   // Next state; a sample leaves the counter pending until its reload is known.
   always_comb begin
      queue_in   = queue_ff;
      qold_in    = qold_ff;
      count_in   = count_ff;
      pending_in = pending_ff;
      if (go) begin
         queue_in = q_now;
         if (sample) begin
            qold_in    = q_now;
            pending_in = 1'b1;
         end else if (accepted) begin
            count_in = count_ff - qcncp_pkg::CNT_W'(len);
         end
      end
      if (reload_we) begin
         count_in   = reload_value;
         pending_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         queue_ff   <= '0;
         qold_ff    <= '0;
         count_ff   <= '0;
         pending_ff <= 1'b0;
      end else begin
         queue_ff   <= queue_in;
         qold_ff    <= qold_in;
         count_ff   <= count_in;
         pending_ff <= pending_in;
      end
   end

endmodule

>>> rtl/core/qcncp_feedback.sv
// Six-stage elastic pipeline that computes and quantizes the congestion feedback.
module qcncp_feedback (
   input  logic                          clock,
   input  logic                          reset,
   input  qcncp_pkg::cfg_type            cfg,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  qcncp_pkg::cp_item_type        in_item,
   output logic                          out_valid,
   input  logic                          out_ready,
   output qcncp_pkg::fb_out_type         out_item
);

   typedef struct packed {
      logic                                  accepted;
      logic                                  sample;
      logic [qcncp_pkg::RND_W-1:0]           rnd;
      logic [qcncp_pkg::QUEUE_W-1:0]         q_now;
      logic signed [qcncp_pkg::DIFF_W-1:0]   offset;
      logic signed [qcncp_pkg::DIFF_W-1:0]   delta;
   } fb_carry_type;

   logic [6:1] valid_ff, valid_in;
   logic [6:1] rdy;
   logic [6:1] prev_valid;
   logic [6:1] load;

   qcncp_pkg::cp_item_type s1_ff;
   fb_carry_type           carry_ff [6:2];
   fb_carry_type           carry2_in;

   logic signed [qcncp_pkg::DIFF_W-1:0] offset_in, delta_in;
   logic signed [qcncp_pkg::RAW_W-1:0]  wdelta_ff, wdelta_in;
   logic signed [qcncp_pkg::RAW_W-1:0]  raw;
   logic [qcncp_pkg::NEG_W-1:0]         neg3_ff, neg3_in;
   logic [qcncp_pkg::NEG_W-1:0]         neg4_ff;
   logic [qcncp_pkg::KBQ_W-1:0]         q0_ff, q0_in;
   logic [qcncp_pkg::KBQ_W-1:0]         kb, lim;
   logic [qcncp_pkg::MAG_W-1:0]         mag_ff, mag_in;
   logic [qcncp_pkg::QUANT_W-1:0]       quant_ff, quant_in;

   // Handshake chain: a stage takes a new item when it is empty or its item moves on.
   always_comb begin
      rdy[6] = !valid_ff[6] || out_ready;
      for (int k = 5; k >= 1; k--) begin
         rdy[k] = !valid_ff[k] || rdy[k+1];
      end
      prev_valid[1] = in_valid;
      for (int k = 2; k <= 6; k++) begin
         prev_valid[k] = valid_ff[k-1];
      end
      for (int k = 1; k <= 6; k++) begin
         load[k]     = prev_valid[k] && rdy[k];
         valid_in[k] = rdy[k] ? prev_valid[k] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Stage 2: queue offset, queue growth and weighted growth.
   always_comb begin
      offset_in = $signed({1'b0, cfg.eq_point}) - $signed({1'b0, s1_ff.q_now});
      delta_in  = $signed({1'b0, s1_ff.q_now}) - $signed({1'b0, s1_ff.qold});
      wdelta_in = qcncp_pkg::RAW_W'(delta_in) *
                  qcncp_pkg::RAW_W'($signed({1'b0, cfg.weight}));
      carry2_in.accepted = s1_ff.accepted;
      carry2_in.sample   = s1_ff.sample;
      carry2_in.rnd      = s1_ff.rnd;
      carry2_in.q_now    = s1_ff.q_now;
      carry2_in.offset   = offset_in;
      carry2_in.delta    = delta_in;
   end

   // Stage 3: magnitude of a negative raw feedback, zero otherwise.
   always_comb begin
      raw = qcncp_pkg::RAW_W'(carry_ff[2].offset) - wdelta_ff;
      if (carry_ff[2].accepted && (raw < 0)) begin
         neg3_in = qcncp_pkg::NEG_W'(-raw);
      end else begin
         neg3_in = '0;
      end
   end

   // Stage 4: quotient estimate; stage 5: correction and clamp; stage 6: quantize.
   always_comb begin
      q0_in    = qcncp_pkg::kb_quot_est({1'b0, neg3_ff});
      kb       = qcncp_pkg::kb_quot_fix({1'b0, neg4_ff}, q0_ff);
      lim      = (kb < cfg.lo_limit) ? kb : cfg.lo_limit;
      mag_in   = lim[qcncp_pkg::MAG_W-1:0];
      quant_in = qcncp_pkg::quantize6(mag_ff);
   end

   always_ff @(posedge clock) begin
      if (load[1]) begin
         s1_ff <= in_item;
      end
      if (load[2]) begin
         carry_ff[2] <= carry2_in;
         wdelta_ff   <= wdelta_in;
      end
      if (load[3]) begin
         carry_ff[3] <= carry_ff[2];
         neg3_ff     <= neg3_in;
      end
      if (load[4]) begin
         carry_ff[4] <= carry_ff[3];
         neg4_ff     <= neg3_ff;
         q0_ff       <= q0_in;
      end
      if (load[5]) begin
         carry_ff[5] <= carry_ff[4];
         mag_ff      <= mag_in;
      end
      if (load[6]) begin
         carry_ff[6] <= carry_ff[5];
         quant_ff    <= quant_in;
      end
   end

   always_comb begin
      in_ready          = rdy[1];
      out_valid         = valid_ff[6];
      out_item.accepted = carry_ff[6].accepted;
      out_item.sample   = carry_ff[6].sample;
      out_item.rnd      = carry_ff[6].rnd;
      out_item.quant    = quant_ff;
      out_item.offset   = carry_ff[6].offset;
      out_item.delta    = carry_ff[6].delta;
      out_item.q_now    = carry_ff[6].q_now;
   end

endmodule

>>> rtl/core/qcn_congestion_point_unit.sv
// Top level of the QCN congestion point: input register, state, feedback pipeline, result.
// A result passes from the input register through the six feedback stages into the result register.
// Throughput: one item per cycle while the result side does not stall. An arrival that follows
// an arrival which triggered a sample waits until that item's counter reload is known;
// the loop is quantized feedback, period table entry and the reload multiplier.
// Reset is synchronous: queue and sampling state clear, registers take their defaults.
module qcn_congestion_point_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_command,
   input  logic [qcncp_pkg::LEN_W-1:0]            req_frame_bytes,
   input  logic [qcncp_pkg::RND_W-1:0]            req_random_scale,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_accepted,
   output logic                                   rsp_raise_feedback,
   output logic [qcncp_pkg::QUANT_W-1:0]          rsp_quantized_feedback,
   output logic signed [qcncp_pkg::DIFF_W-1:0]    rsp_queue_offset,
   output logic signed [qcncp_pkg::DIFF_W-1:0]    rsp_queue_delta,
   output logic [qcncp_pkg::QUEUE_W-1:0]          rsp_queue_bytes_now,
   input  logic                                   csr_write_enable,
   input  logic [qcncp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [qcncp_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   qcncp_pkg::cfg_type       cfg;
   qcncp_pkg::cp_item_type   s1_item;
   qcncp_pkg::cp_status_type st_status;
   qcncp_pkg::fb_out_type    fb_out;

   logic                          in_valid_ff, in_valid_in;
   logic                          in_cmd_ff;
   logic [qcncp_pkg::LEN_W-1:0]   in_len_ff;
   logic [qcncp_pkg::RND_W-1:0]   in_rnd_ff;
   logic                          req_fire;
   logic                          hold;
   logic                          fb_in_valid;
   logic                          fb_in_ready;
   logic                          s0_go;
   logic                          fb_out_valid;
   logic                          out_ready;
   logic                          out_load;
   logic                          reload_we;
   logic [qcncp_pkg::PERIOD_W-1:0] entry;
   logic [qcncp_pkg::RELOAD_W-1:0] reload_prod;
   logic [qcncp_pkg::CNT_W-1:0]    reload_value;
   logic                           raise;

   logic                                  out_valid_ff, out_valid_in;
   logic                                  out_accepted_ff;
   logic                                  out_raise_ff;
   logic [qcncp_pkg::QUANT_W-1:0]         out_quant_ff;
   logic signed [qcncp_pkg::DIFF_W-1:0]   out_offset_ff;
   logic signed [qcncp_pkg::DIFF_W-1:0]   out_delta_ff;
   logic [qcncp_pkg::QUEUE_W-1:0]         out_qnow_ff;

   qcncp_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cfg              (cfg)
   );

   // Input register; an arrival waits here while the sampling counter is pending.
   always_comb begin
      hold        = st_status.pending && (in_cmd_ff == qcncp_pkg::CMD_ARRIVAL);
      fb_in_valid = in_valid_ff && !hold;
      s0_go       = fb_in_valid && fb_in_ready;
      req_stall   = in_valid_ff && !s0_go;
      req_fire    = req_valid && !req_stall;
      in_valid_in = (in_valid_ff && !s0_go) || req_fire;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_cmd_ff <= req_command;
         in_len_ff <= req_frame_bytes;
         in_rnd_ff <= req_random_scale;
      end
   end

   qcncp_state u_state (
      .clock        (clock),
      .reset        (reset),
      .go           (s0_go),
      .cmd          (in_cmd_ff),
      .len          (in_len_ff),
      .rnd          (in_rnd_ff),
      .max_queue    (cfg.max_queue),
      .reload_we    (reload_we),
      .reload_value (reload_value),
      .item         (s1_item),
      .status       (st_status)
   );

   qcncp_feedback u_feedback (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (fb_in_valid),
      .in_ready  (fb_in_ready),
      .in_item   (s1_item),
      .out_valid (fb_out_valid),
      .out_ready (out_ready),
      .out_item  (fb_out)
   );

   // Counter reload from the period selected by the quantized feedback.
   always_comb begin
      out_ready    = !out_valid_ff || !rsp_stall;
      out_load     = fb_out_valid && out_ready;
      reload_we    = out_load && fb_out.sample;
      entry        = qcncp_pkg::period_entry(cfg.periods, fb_out.quant[5:3]);
      reload_prod  = qcncp_pkg::RELOAD_W'(entry) * qcncp_pkg::RELOAD_W'(fb_out.rnd);
      reload_value = reload_prod[qcncp_pkg::RELOAD_W-1:qcncp_pkg::RND_SHIFT];
      raise        = fb_out.sample && (fb_out.quant != '0) && cfg.qcn_enable;
      out_valid_in = out_ready ? fb_out_valid : out_valid_ff;
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_accepted_ff <= fb_out.accepted;
         out_raise_ff    <= raise;
         out_quant_ff    <= fb_out.quant;
         out_offset_ff   <= fb_out.offset;
         out_delta_ff    <= fb_out.delta;
         out_qnow_ff     <= fb_out.q_now;
      end
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_accepted           = out_accepted_ff;
   assign rsp_raise_feedback     = out_raise_ff;
   assign rsp_quantized_feedback = out_quant_ff;
   assign rsp_queue_offset       = out_offset_ff;
   assign rsp_queue_delta        = out_delta_ff;
   assign rsp_queue_bytes_now    = out_qnow_ff;

   // A sampled item leaves the counter pending until its reload is written.
   a_sample_sets_pending: assert property (@(posedge clock) disable iff (reset)
      (s0_go && s1_item.sample) |=> st_status.pending)
      else $error("sampled item did not mark the counter pending");

   // The reload write releases the counter.
   a_reload_clears_pending: assert property (@(posedge clock) disable iff (reset)
      reload_we |=> !st_status.pending)
      else $error("counter still pending after reload");

   // Nonzero feedback only comes from an enqueued arrival.
   a_quant_needs_accept: assert property (@(posedge clock) disable iff (reset)
      (out_load && (fb_out.quant != '0)) |=> rsp_accepted)
      else $error("feedback reported for an item that was not enqueued");

endmodule

>>> tb/qcn_congestion_point_checker.sv
// Checker for the QCN congestion point: predicts each result and compares it with the block.
module qcn_congestion_point_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_stall,
   input  logic                                   req_command,
   input  logic [qcncp_pkg::LEN_W-1:0]            req_frame_bytes,
   input  logic [qcncp_pkg::RND_W-1:0]            req_random_scale,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   input  logic                                   rsp_accepted,
   input  logic                                   rsp_raise_feedback,
   input  logic [qcncp_pkg::QUANT_W-1:0]          rsp_quantized_feedback,
   input  logic signed [qcncp_pkg::DIFF_W-1:0]    rsp_queue_offset,
   input  logic signed [qcncp_pkg::DIFF_W-1:0]    rsp_queue_delta,
   input  logic [qcncp_pkg::QUEUE_W-1:0]          rsp_queue_bytes_now,
   input  logic                                   csr_write_enable,
   input  logic [qcncp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [qcncp_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output int                                     mismatch_count,
   output int                                     pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   // One feedback result as the block should report it.
   typedef struct packed {
      logic                                  accepted;
      logic                                  raise;
      logic [qcncp_pkg::QUANT_W-1:0]         quant;
      logic signed [qcncp_pkg::DIFF_W-1:0]   offset;
      logic signed [qcncp_pkg::DIFF_W-1:0]   delta;
      logic [qcncp_pkg::QUEUE_W-1:0]         level;
   } feedback_result_type;

   feedback_result_type expected_feedback [$];
   int fault_total;

   // Configuration copy.
   logic [qcncp_pkg::QUEUE_W-1:0]    eq_bytes;
   logic [qcncp_pkg::WEIGHT_W-1:0]   growth_weight;
   logic [qcncp_pkg::QUEUE_W-1:0]    max_bytes;
   logic                             feedback_enable;
   logic [qcncp_pkg::CSR_DATA_W-1:0] period_words [qcncp_pkg::PERIOD_REGS];

   // Queue and sampling state copy.
   logic [qcncp_pkg::QUEUE_W-1:0]    queue_level;
   logic [qcncp_pkg::QUEUE_W-1:0]    sampled_level;
   longint                           sample_countdown;

   // Each period register holds two 32-bit table entries, the even one in the low half.
   function automatic longint period_for(input int idx);
      logic [qcncp_pkg::CSR_DATA_W-1:0] word;
      word = period_words[idx >> 1];
      return (idx & 1) ? longint'(word[63:32]) : longint'(word[31:0]);
   endfunction

   // Small magnitudes pass; larger ones keep their six leading bits.
   function automatic logic [qcncp_pkg::QUANT_W-1:0] quantize_magnitude(input longint mag);
      int msb;
      msb = 0;
      if (mag < 64) begin
         return mag[qcncp_pkg::QUANT_W-1:0];
      end
      for (int b = 0; b < 40; b++) begin
         if (mag[b]) begin
            msb = b;
         end
      end
      return qcncp_pkg::QUANT_W'(mag >> (msb - 5));
   endfunction

   task automatic restore_defaults();
      eq_bytes         = '0;
      growth_weight    = qcncp_pkg::WEIGHT_RESET;
      max_bytes        = qcncp_pkg::MAX_QUEUE_RESET;
      feedback_enable  = qcncp_pkg::QCN_ENABLE_RESET;
      for (int i = 0; i < qcncp_pkg::PERIOD_REGS; i++) begin
         period_words[i] = '0;
      end
      queue_level      = '0;
      sampled_level    = '0;
      sample_countdown = period_for(0);
   endtask

   // Bits above a register's width are dropped.
   task automatic apply_register(input logic [qcncp_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [qcncp_pkg::CSR_DATA_W-1:0] value);
      case (idx)
         qcncp_pkg::CSR_EQ_POINT:    eq_bytes        = value[qcncp_pkg::QUEUE_W-1:0];
         qcncp_pkg::CSR_WEIGHT:      growth_weight   = value[qcncp_pkg::WEIGHT_W-1:0];
         qcncp_pkg::CSR_MAX_QUEUE:   max_bytes       = value[qcncp_pkg::QUEUE_W-1:0];
         qcncp_pkg::CSR_QCN_ENABLE:  feedback_enable = value[0];
         qcncp_pkg::CSR_PERIODS_0_1: period_words[0] = value;
         qcncp_pkg::CSR_PERIODS_2_3: period_words[1] = value;
         qcncp_pkg::CSR_PERIODS_4_5: period_words[2] = value;
         qcncp_pkg::CSR_PERIODS_6_7: period_words[3] = value;
         default: ;
      endcase
   endtask

   // Updates the queue and sampling state for one item and queues its result.
   task automatic predict_frame(input logic cmd, input logic [qcncp_pkg::LEN_W-1:0] len,
                                input logic [qcncp_pkg::RND_W-1:0] scale);
      feedback_result_type r;
      logic [qcncp_pkg::QUEUE_W-1:0] level_at_sample;
      longint eq, q, raw, fb, floor_kb;
      r = '0;
      level_at_sample = sampled_level;
      if (cmd == qcncp_pkg::CMD_DEPARTURE) begin
         // The queue never goes below empty.
         queue_level = (queue_level > len) ? queue_level - len : '0;
      end else if (longint'(queue_level) + longint'(len) <= longint'(max_bytes)) begin
         r.accepted  = 1'b1;
         queue_level = queue_level + len;
         eq  = longint'(eq_bytes);
         q   = longint'(queue_level);
         raw = (eq - q) - longint'(growth_weight) * (q - longint'(level_at_sample));
         // Whole kilobytes, cut toward zero, then clamped to the negative range.
         fb       = raw / qcncp_pkg::KBYTE;
         floor_kb = -((eq * (2 * longint'(growth_weight) + 1)) / qcncp_pkg::KBYTE);
         if (fb < floor_kb) begin
            fb = floor_kb;
         end else if (fb > 0) begin
            fb = 0;
         end
         r.quant = quantize_magnitude(-fb);
         // A sample is taken once the byte countdown goes negative.
         sample_countdown -= longint'(len);
         if (sample_countdown < 0) begin
            r.raise          = (r.quant != '0) && feedback_enable;
            sampled_level    = queue_level;
            sample_countdown = (period_for(int'(r.quant >> 3)) * longint'(scale))
                               >> qcncp_pkg::RND_SHIFT;
         end
      end
      r.offset = qcncp_pkg::DIFF_W'(longint'(eq_bytes) - longint'(queue_level));
      r.delta  = qcncp_pkg::DIFF_W'(longint'(queue_level) - longint'(level_at_sample));
      r.level  = queue_level;
      expected_feedback = {expected_feedback, r};
   endtask

   task automatic check_field(input string field, input longint want, input longint got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
         fault_total++;
      end
   endtask

   // Watch the register port and both channels at each clock edge.
   always @(posedge clock) begin
      feedback_result_type want;
      if (reset) begin
         restore_defaults();
         expected_feedback.delete();
         fault_total = 0;
      end else begin
         if (csr_write_enable) begin
            apply_register(csr_index, csr_wdata);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_feedback.size() == 0) begin
               $display("%0t: expected no result, got one with queue_bytes_now %0d",
                        $time, rsp_queue_bytes_now);
               fault_total++;
            end else begin
               want = expected_feedback.pop_front();
               check_field("accepted", want.accepted, rsp_accepted);
               check_field("raise_feedback", want.raise, rsp_raise_feedback);
               check_field("quantized_feedback", want.quant, rsp_quantized_feedback);
               check_field("queue_offset", want.offset, rsp_queue_offset);
               check_field("queue_delta", want.delta, rsp_queue_delta);
               check_field("queue_bytes_now", want.level, rsp_queue_bytes_now);
            end
         end
         if (req_valid && !req_stall) begin
            predict_frame(req_command, req_frame_bytes, req_random_scale);
         end
      end
      mismatch_count  <= fault_total;
      pending_results <= expected_feedback.size();
   end

endmodule

>>> tb/qcn_congestion_point_unit_tb.sv
// Top of the QCN congestion point testbench: clock, reset, stimulus, stalls and verdict.
module qcn_congestion_point_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT     = 3000;
   localparam int HOLD_OFF_CYCLES = 150;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_pattern_type;

   logic                                  clock = 1'b0;
   logic                                  reset;
   logic                                  req_valid;
   logic                                  req_stall;
   logic                                  req_command;
   logic [qcncp_pkg::LEN_W-1:0]           req_frame_bytes;
   logic [qcncp_pkg::RND_W-1:0]           req_random_scale;
   logic                                  rsp_valid;
   logic                                  rsp_stall = 1'b0;
   logic                                  rsp_accepted;
   logic                                  rsp_raise_feedback;
   logic [qcncp_pkg::QUANT_W-1:0]         rsp_quantized_feedback;
   logic signed [qcncp_pkg::DIFF_W-1:0]   rsp_queue_offset;
   logic signed [qcncp_pkg::DIFF_W-1:0]   rsp_queue_delta;
   logic [qcncp_pkg::QUEUE_W-1:0]         rsp_queue_bytes_now;
   logic                                  csr_write_enable;
   logic [qcncp_pkg::CSR_IDX_W-1:0]       csr_index;
   logic [qcncp_pkg::CSR_DATA_W-1:0]      csr_wdata;
   int                                    mismatch_count;
   int                                    pending_results;

   // Sender pacing and receiver hold-off requests.
   int                burst_left = 0;
   int                max_gap = 0;
   int                hold_off_wanted = 0;
   int                hold_off_seen;
   int                hold_left;
   int                pattern_left;
   stall_pattern_type stall_pattern;
   int                quiet_cycles;
   logic [31:0]       period_plan [8];

   qcn_congestion_point_unit DUT (.*);

   qcn_congestion_point_checker feedback_checker (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Receiver: random stall patterns, plus long hold-offs when the stimulus asks.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall     <= 1'b0;
         hold_off_seen = 0;
         hold_left     = 0;
         pattern_left  = 0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_off_seen != hold_off_wanted) begin
         hold_off_seen++;
         hold_left = HOLD_OFF_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         if (pattern_left == 0) begin
            stall_pattern = stall_pattern_type'($urandom_range(0, 3));
            pattern_left  = $urandom_range(4, 64);
         end
         pattern_left--;
         case (stall_pattern)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default:     rsp_stall <= ~rsp_stall;
         endcase
      end
   end

   // Watchdog: ends the run when neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // Offers one item, after a random gap when a burst has ended.
   task automatic offer_frame(input logic cmd, input logic [qcncp_pkg::LEN_W-1:0] len,
                              input logic [qcncp_pkg::RND_W-1:0] scale);
      int gap;
      if (burst_left == 0) begin
         gap = (max_gap > 0) ? $urandom_range(0, max_gap) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_command      <= cmd;
      req_frame_bytes  <= len;
      req_random_scale <= scale;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Mostly mid-sized frames, with empty, maximal and fully random lengths mixed in.
   function automatic logic [qcncp_pkg::LEN_W-1:0] frame_length();
      int sel;
      sel = $urandom_range(0, 15);
      if (sel == 0) begin
         return '0;
      end else if (sel == 1) begin
         return '1;
      end else if (sel < 4) begin
         return qcncp_pkg::LEN_W'($urandom_range(0, 16383));
      end
      return qcncp_pkg::LEN_W'($urandom_range(64, 3000));
   endfunction

   task automatic random_frames(input int count, input int arrival_pct);
      logic cmd;
      for (int i = 0; i < count; i++) begin
         cmd = ($urandom_range(0, 99) < arrival_pct) ? qcncp_pkg::CMD_ARRIVAL
                                                      : qcncp_pkg::CMD_DEPARTURE;
         offer_frame(cmd, frame_length(), qcncp_pkg::RND_W'($urandom_range(0, 255)));
      end
   endtask

   // Stops offering and waits until every expected result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   task automatic write_register(input qcncp_pkg::csr_index_type idx,
                                 input logic [qcncp_pkg::CSR_DATA_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_wdata        <= value;
      @(posedge clock);
   endtask

   // Writes every register; unused upper data bits carry noise.
   task automatic program_point(input logic [qcncp_pkg::QUEUE_W-1:0] eq_target,
                                input logic [qcncp_pkg::WEIGHT_W-1:0] weight_value,
                                input logic [qcncp_pkg::QUEUE_W-1:0] queue_cap,
                                input logic enable_fb);
      write_register(qcncp_pkg::CSR_EQ_POINT, {32'($urandom), 8'($urandom), eq_target});
      write_register(qcncp_pkg::CSR_WEIGHT, {32'($urandom), 28'($urandom), weight_value});
      write_register(qcncp_pkg::CSR_MAX_QUEUE, {32'($urandom), 8'($urandom), queue_cap});
      write_register(qcncp_pkg::CSR_QCN_ENABLE, {32'($urandom), 31'($urandom), enable_fb});
      write_register(qcncp_pkg::CSR_PERIODS_0_1, {period_plan[1], period_plan[0]});
      write_register(qcncp_pkg::CSR_PERIODS_2_3, {period_plan[3], period_plan[2]});
      write_register(qcncp_pkg::CSR_PERIODS_4_5, {period_plan[5], period_plan[4]});
      write_register(qcncp_pkg::CSR_PERIODS_6_7, {period_plan[7], period_plan[6]});
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      logic [qcncp_pkg::QUEUE_W-1:0] eq_target;
      logic [qcncp_pkg::WEIGHT_W-1:0] weight_value;
      logic [qcncp_pkg::QUEUE_W-1:0] queue_cap;
      int sel;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_command      = qcncp_pkg::CMD_ARRIVAL;
      req_frame_bytes  = '0;
      req_random_scale = '0;
      csr_write_enable = 1'b0;
      csr_index        = qcncp_pkg::CSR_EQ_POINT;
      csr_wdata        = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: zero periods sample on every nonempty arrival, feedback stays zero.
      max_gap = 4;
      offer_frame(qcncp_pkg::CMD_ARRIVAL, 14'd0, 8'd0);
      offer_frame(qcncp_pkg::CMD_ARRIVAL, 14'd16383, 8'd255);
      offer_frame(qcncp_pkg::CMD_ARRIVAL, 14'd1, 8'd128);
      offer_frame(qcncp_pkg::CMD_DEPARTURE, 14'd100, 8'd1);
      offer_frame(qcncp_pkg::CMD_DEPARTURE, 14'd16383, 8'd254);
      offer_frame(qcncp_pkg::CMD_ARRIVAL, 14'd5000, 8'd127);
      offer_frame(qcncp_pkg::CMD_DEPARTURE, 14'd5000, 8'd0);
      drain_results();

      // Small capacity: fill to exactly full, then drops; empty arrival at the limit.
      for (int i = 0; i < 8; i++) begin
         period_plan[i] = 32'(700 * (i + 1));
      end
      program_point(24'd30000, 4'd15, 24'd50000, 1'b1);
      repeat (3) offer_frame(qcncp_pkg::CMD_ARRIVAL, 14'd16383, 8'd200);
      offer_frame(qcncp_pkg::CMD_ARRIVAL, 14'd16383, 8'd85);
      offer_frame(qcncp_pkg::CMD_ARRIVAL, 14'd851, 8'd170);
      offer_frame(qcncp_pkg::CMD_ARRIVAL, 14'd1, 8'd255);
      offer_frame(qcncp_pkg::CMD_ARRIVAL, 14'd0, 8'd64);
      offer_frame(qcncp_pkg::CMD_DEPARTURE, 14'd16383, 8'd0);
      offer_frame(qcncp_pkg::CMD_DEPARTURE, 14'd1, 8'd2);
      drain_results();

      // Zero capacity and all-zero settings: only an empty arrival on an empty queue fits.
      program_point(24'd0, 4'd0, 24'd0, 1'b0);
      repeat (3) offer_frame(qcncp_pkg::CMD_DEPARTURE, 14'd16383, 8'd33);
      offer_frame(qcncp_pkg::CMD_ARRIVAL, 14'd0, 8'd16);
      offer_frame(qcncp_pkg::CMD_ARRIVAL, 14'd1, 8'd8);
      offer_frame(qcncp_pkg::CMD_ARRIVAL, 14'd16383, 8'd4);
      drain_results();

      // Random settings per phase, with random traffic in between.
      for (int ph = 3; ph < 15; ph++) begin
         sel = $urandom_range(0, 7);
         if (sel == 0) begin
            eq_target = '0;
         end else if (sel == 1) begin
            eq_target = '1;
         end else if (sel == 2) begin
            eq_target = qcncp_pkg::QUEUE_W'($urandom);
         end else begin
            eq_target = qcncp_pkg::QUEUE_W'($urandom_range(0, 150000));
         end
         weight_value = (ph == 3) ? 4'd0 :
                        (ph == 4) ? 4'd15 :
                        qcncp_pkg::WEIGHT_W'($urandom_range(0, 15));
         queue_cap = ($urandom_range(0, 3) == 0) ?
                     qcncp_pkg::QUEUE_W'($urandom_range(20000, 400000)) : '1;
         for (int i = 0; i < 8; i++) begin
            if (ph == 6 || $urandom_range(0, 9) == 0) begin
               period_plan[i] = '0;
            end else begin
               period_plan[i] = $urandom_range(1, 40000);
            end
         end
         program_point(eq_target, weight_value, queue_cap, $urandom_range(0, 4) != 0);
         max_gap = (ph % 3 == 0) ? 0 : $urandom_range(2, 12);
         // Long receiver hold-off while the sender keeps offering.
         if (ph == 5 || ph == 11) begin
            max_gap = 0;
            hold_off_wanted <= hold_off_wanted + 1;
         end
         random_frames(90, $urandom_range(40, 70));
         drain_results();
      end

      // Largest periods last, since a reload from them with a nonzero scale stops sampling for good.
      for (int i = 0; i < 8; i++) begin
         period_plan[i] = '1;
      end
      program_point('1, 4'd15, '1, 1'b1);
      max_gap = 6;
      random_frames(40, 70);
      drain_results();

      // Let any stray result show up before the verdict.
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && pending_results == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/qcncp_pkg.sv
rtl/core/qcncp_csr.sv
rtl/core/qcncp_state.sv
rtl/core/qcncp_feedback.sv
rtl/core/qcn_congestion_point_unit.sv
tb/qcn_congestion_point_checker.sv
tb/qcn_congestion_point_unit_tb.sv
